FILE: rtl/salc_pkg.sv
// Package for the set-associative LRU cache lookup block.
// Sizes, register codes, state machine encoding and control structs.
// No dependencies; imported by every module of the block except salc_ram.
`default_nettype none

package salc_pkg;

   localparam int ADDR_BITS = 32;
   localparam int SET_BITS  = 6;
   localparam int MAX_WAYS  = 8;

   localparam int NUM_SETS  = 1 << SET_BITS;
   localparam int WAY_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_BITS = WAY_BITS;
   localparam int MISS_BITS = 32;
   localparam int WAYS_CFG_BITS = 4;

   // index map scanner
   localparam int POS_BITS  = $clog2(ADDR_BITS);
   localparam int KCNT_BITS = $clog2(SET_BITS + 1);
   localparam int KIDX_BITS = (SET_BITS > 1) ? $clog2(SET_BITS) : 1;

   // memory rows, one per set
   localparam int TAG_ROW_BITS = MAX_WAYS * ADDR_BITS;
   localparam int META_BITS    = MAX_WAYS * (RANK_BITS + 1);

   // result word: hit, set_index, way_used, miss_total
   localparam int RSP_BITS       = 1 + SET_BITS + WAY_BITS + MISS_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [ADDR_BITS-1:0]     INDEX_MASK_RESET = ADDR_BITS'(63);
   localparam logic [WAYS_CFG_BITS-1:0] WAYS_RESET       = WAYS_CFG_BITS'(MAX_WAYS);

   typedef enum logic {
      REG_INDEX_MASK,
      REG_WAYS_IN_USE
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_MAP,
      ST_IDLE,
      ST_LOOK
   } state_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
      logic [MAX_WAYS-1:0]                vld;
   } meta_type;

   typedef struct packed {
      logic accept;   // latch address and set, read the set row
      logic update;   // resolve lookup, write back row, load result
   } ctrl_cmd_type;

   typedef struct packed {
      logic map_busy;
      logic slot_free;
   } ctrl_sts_type;

endpackage

`default_nettype wire

FILE: rtl/salc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/salc_idxmap.sv
// Set index gather: scans index_mask one bit a cycle into a table of
// selected address bit positions, then gathers the set index from an address.
// Depends on salc_pkg.
`default_nettype none

module salc_idxmap import salc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [ADDR_BITS-1:0] mask,
   input  wire logic [ADDR_BITS-1:0] address,
   output      logic [SET_BITS-1:0]  set_index,
   output      logic                 busy
);

   logic                 busy_ff, busy_in;
   logic [POS_BITS-1:0]  bit_ff, bit_in;
   logic [KCNT_BITS-1:0] k_ff, k_in;
   logic [SET_BITS-1:0]  sel_ff, sel_in;
   logic [POS_BITS-1:0]  pos_ff [SET_BITS];
   logic [POS_BITS-1:0]  pos_in [SET_BITS];

   always_comb begin
      busy_in = busy_ff;
      bit_in  = bit_ff;
      k_in    = k_ff;
      sel_in  = sel_ff;
      pos_in  = pos_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = '0;
         k_in    = '0;
         sel_in  = '0;
      end else if (busy_ff) begin
         // lowest selected bits fill index bits from 0 upward
         if (mask[bit_ff] && (k_ff < KCNT_BITS'(SET_BITS))) begin
            pos_in[k_ff[KIDX_BITS-1:0]] = bit_ff;
            sel_in[k_ff[KIDX_BITS-1:0]] = 1'b1;
            k_in = k_ff + KCNT_BITS'(1);
         end
         if (bit_ff == POS_BITS'(ADDR_BITS - 1)) begin
            busy_in = 1'b0;
         end else begin
            bit_in = bit_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         bit_ff  <= '0;
         k_ff    <= '0;
         sel_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
         k_ff    <= k_in;
         sel_ff  <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   // missing high index bits read as zero
   always_comb begin
      for (int k = 0; k < SET_BITS; k++) begin
         set_index[k] = sel_ff[k] & address[pos_ff[k]];
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

FILE: rtl/salc_ctrl.sv
// Controller state machine: index map wait, idle/accept, lookup/write-back.
// Depends on salc_pkg.
`default_nettype none

module salc_ctrl import salc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire ctrl_sts_type sts,
   output      ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_MAP: begin
            if (!sts.map_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (sts.map_busy) begin
               state_in = ST_MAP;
            end else if (req_tvalid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_MAP;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !sts.map_busy;
            cmd.accept = !sts.map_busy && req_tvalid;
         end
         ST_LOOK: begin
            cmd.update = sts.slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MAP;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_LOOK)
      else $error("accepted word did not enter lookup");

   a_hold_while_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && !sts.slot_free) |=> (state_ff == ST_LOOK && !req_tready))
      else $error("lookup left while result slot full");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("input ready outside idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/salc_dpath.sv
// Datapath: tag and metadata memories (one row per set), row valid flags,
// way compare, LRU choice and rank update, miss counter, result register.
// Depends on salc_pkg and salc_ram.
`default_nettype none

module salc_dpath import salc_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctrl_cmd_type              cmd,
   output      ctrl_sts_type              sts,
   input  wire logic                      map_busy,
   input  wire logic [ADDR_BITS-1:0]      req_address,
   input  wire logic [SET_BITS-1:0]       req_set,
   input  wire logic [WAYS_CFG_BITS-1:0]  ways_in_use,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   logic [ADDR_BITS-1:0] addr_ff;
   logic [SET_BITS-1:0]  set_ff;
   logic [SET_BITS-1:0]  rd_addr;
   logic [NUM_SETS-1:0]  row_vld_ff;
   logic                 row_ok_ff;
   logic [MISS_BITS-1:0] miss_ff, miss_in;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [SET_BITS-1:0]  rsp_set_ff;
   logic [WAY_BITS-1:0]  rsp_way_ff;

   logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_rd, tag_wr;
   meta_type meta_rd, meta_wr;
   logic [META_BITS-1:0] meta_rd_bits;

   logic [WAYS_CFG_BITS-1:0]           n_ways;
   logic [MAX_WAYS-1:0]                active, vld;
   logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
   logic                               hit, found;
   logic [WAY_BITS-1:0]                hit_way, empty_way, lru_way, chosen;
   logic [RANK_BITS-1:0]               best;
   logic [RANK_BITS:0]                 old_rank;

   assign rd_addr = cmd.accept ? req_set : set_ff;

   salc_ram #(.WIDTH(TAG_ROW_BITS), .DEPTH(NUM_SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (set_ff),
      .wr_data (tag_wr),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   salc_ram #(.WIDTH(META_BITS), .DEPTH(NUM_SETS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (set_ff),
      .wr_data (meta_wr),
      .rd_addr (rd_addr),
      .rd_data (meta_rd_bits)
   );

   assign meta_rd = meta_type'(meta_rd_bits);

   // a set row never written reads as all ways empty, ranks zero
   always_comb begin
      n_ways = ways_in_use;
      if (n_ways == '0) begin
         n_ways = WAYS_CFG_BITS'(1);
      end
      if (n_ways > WAYS_CFG_BITS'(MAX_WAYS)) begin
         n_ways = WAYS_CFG_BITS'(MAX_WAYS);
      end
      vld  = row_ok_ff ? meta_rd.vld  : '0;
      rank = row_ok_ff ? meta_rd.rank : '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         active[w] = WAYS_CFG_BITS'(w) < n_ways;
      end
   end

   // lowest matching way, lowest empty way
   always_comb begin
      hit       = 1'b0;
      found     = 1'b0;
      hit_way   = '0;
      empty_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (active[w] && vld[w] && (tag_rd[w] == addr_ff)) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (active[w] && !vld[w]) begin
            found     = 1'b1;
            empty_way = WAY_BITS'(w);
         end
      end
   end

   // lowest way with the largest rank
   always_comb begin
      best    = rank[0];
      lru_way = '0;
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (active[w] && (rank[w] > best)) begin
            best    = rank[w];
            lru_way = WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      if (hit) begin
         chosen = hit_way;
      end else if (found) begin
         chosen = empty_way;
      end else begin
         chosen = lru_way;
      end
      // an empty way ages every valid way below the top rank
      old_rank = vld[chosen] ? {1'b0, rank[chosen]} : (RANK_BITS + 1)'(MAX_WAYS);
   end

   always_comb begin
      meta_wr = '0;
      tag_wr  = tag_rd;
      for (int w = 0; w < MAX_WAYS; w++) begin
         meta_wr.vld[w]  = vld[w];
         meta_wr.rank[w] = rank[w];
         if (WAY_BITS'(w) == chosen) begin
            meta_wr.vld[w]  = 1'b1;
            meta_wr.rank[w] = '0;
            tag_wr[w]       = addr_ff;
         end else if (vld[w] && ({1'b0, rank[w]} < old_rank)
                      && (rank[w] < RANK_BITS'(MAX_WAYS - 1))) begin
            meta_wr.rank[w] = rank[w] + RANK_BITS'(1);
         end
      end
   end

   always_comb begin
      miss_in = miss_ff;
      if (cmd.update && !hit && (miss_ff != '1)) begin
         miss_in = miss_ff + MISS_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff   <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         miss_ff <= miss_in;
         if (cmd.update) begin
            row_vld_ff[set_ff] <= 1'b1;
            rsp_valid_ff       <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ok_ff <= row_vld_ff[rd_addr];
      if (cmd.accept) begin
         addr_ff <= req_address;
         set_ff  <= req_set;
      end
      if (cmd.update) begin
         rsp_hit_ff <= hit;
         rsp_set_ff <= set_ff;
         rsp_way_ff <= chosen;
      end
   end

   // miss_ff only moves on update, so it belongs to the held result
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = RSP_TDATA_BITS'({miss_ff, rsp_way_ff, rsp_set_ff, rsp_hit_ff});
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;
   assign sts.map_busy  = map_busy;

`ifndef ASSERT_OFF
   a_update_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while full");

   a_miss_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> miss_ff >= $past(miss_ff))
      else $error("miss total decreased");

   a_hit_keeps_misses: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && hit) |=> (miss_ff == $past(miss_ff)) && rsp_tvalid)
      else $error("hit changed miss total or lost result");
`endif

endmodule

`default_nettype wire

FILE: rtl/set_assoc_lru_cache_lookup.sv
// Top level of the set-associative LRU cache lookup block: configuration
// registers, index map, controller and datapath.
// Depends on salc_pkg, salc_idxmap, salc_ctrl, salc_dpath.
//
//   channel  dir  ports        word
//   req      in   req_t*       address
//   rsp      out  rsp_t*       hit, set_index, way_used, miss_total
//   csr      in   csr_p*       index_mask at 0x0, ways_in_use at 0x4
//
// For each word, the accept cycle reads the set row from the tag and metadata
// memories; the lookup state then compares ways, picks the way and writes the
// row back once the result register is free. A new word is taken in the cycle
// after that. After reset and after each index_mask write, the index map scan
// steps through index_mask one bit a cycle with req_tready low.
// A waiting result sits in the output register; the next word is still
// accepted and holds in lookup until that register is taken.
`default_nettype none

module set_assoc_lru_cache_lookup import salc_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic [ADDR_BITS-1:0]      req_tdata,   // [31:0] address
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [0] hit, [6:1] set_index, [9:7] way_used, [41:10] miss_total, rest zero
   output      logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output      logic                      csr_pready
);

   logic [ADDR_BITS-1:0]     index_mask_ff, index_mask_in;
   logic [WAYS_CFG_BITS-1:0] ways_ff, ways_in;
   logic                     csr_wr;
   logic                     map_start;
   csr_reg_type              csr_reg;
   logic                     map_busy;
   logic [SET_BITS-1:0]      req_set;
   ctrl_cmd_type             cmd;
   ctrl_sts_type             sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      index_mask_in = index_mask_ff;
      ways_in       = ways_ff;
      map_start     = 1'b0;
      if (csr_wr) begin
         case (csr_reg)
            REG_INDEX_MASK: begin
               index_mask_in = csr_pwdata[ADDR_BITS-1:0];
               map_start     = 1'b1;
            end
            REG_WAYS_IN_USE: begin
               ways_in = csr_pwdata[WAYS_CFG_BITS-1:0];
            end
            default: begin
               map_start = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_INDEX_MASK:  csr_prdata = CSR_DATA_BITS'(index_mask_ff);
         REG_WAYS_IN_USE: csr_prdata = CSR_DATA_BITS'(ways_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_mask_ff <= INDEX_MASK_RESET;
         ways_ff       <= WAYS_RESET;
      end else begin
         index_mask_ff <= index_mask_in;
         ways_ff       <= ways_in;
      end
   end

   salc_idxmap u_idxmap (
      .clock     (clock),
      .reset     (reset),
      .start     (map_start),
      .mask      (index_mask_ff),
      .address   (req_tdata),
      .set_index (req_set),
      .busy      (map_busy)
   );

   salc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   salc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .map_busy    (map_busy),
      .req_address (req_tdata),
      .req_set     (req_set),
      .ways_in_use (ways_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire
